FILE: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked at every clock edge out of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pts_pkg.sv
`default_nettype none

package pts_pkg;

  // Operation codes carried in the input item.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_YIELD  = 2'd3
  } opcode_t;

  // Fault codes reported with each result.
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_FULL     = 2'd1;
  localparam logic [1:0] FAULT_OCCUPIED = 2'd2;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    U_FETCH,
    U_ADD,
    U_WAIT,
    U_SIGNAL,
    U_SCAN_INIT,
    U_SCAN,
    U_COMMIT,
    U_EMIT
  } upc_t;

  // Condition under which a step is allowed to execute.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  // Datapath action of a step.
  typedef enum logic [2:0] {
    ACT_LATCH,
    ACT_ADD,
    ACT_WAIT,
    ACT_SIGNAL,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_COMMIT,
    ACT_EMIT
  } act_t;

  // Sequencing of a step.
  typedef enum logic [1:0] {
    J_GOTO,
    J_DISPATCH,
    J_IF_SLOT,
    J_LOOP
  } jump_t;

  typedef struct packed {
    hold_t hold;
    act_t  act;
    jump_t jump;
    upc_t  target;
  } ucode_t;

  // Control store of the sequencer.
  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    case (addr)
      U_FETCH:     w = '{HOLD_IN,   ACT_LATCH,     J_DISPATCH, U_FETCH};
      U_ADD:       w = '{HOLD_NONE, ACT_ADD,       J_GOTO,     U_EMIT};
      U_WAIT:      w = '{HOLD_NONE, ACT_WAIT,      J_IF_SLOT,  U_SCAN_INIT};
      U_SIGNAL:    w = '{HOLD_NONE, ACT_SIGNAL,    J_GOTO,     U_EMIT};
      U_SCAN_INIT: w = '{HOLD_NONE, ACT_SCAN_INIT, J_GOTO,     U_SCAN};
      U_SCAN:      w = '{HOLD_NONE, ACT_SCAN_STEP, J_LOOP,     U_COMMIT};
      U_COMMIT:    w = '{HOLD_NONE, ACT_COMMIT,    J_GOTO,     U_EMIT};
      U_EMIT:      w = '{HOLD_OUT,  ACT_EMIT,      J_GOTO,     U_FETCH};
      default:     w = '{HOLD_IN,   ACT_LATCH,     J_DISPATCH, U_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/priority_task_scheduler_top.sv
// Add and signal run their own step and then emit, as does a wait on an out-of-range
// condition; yield and an in-range wait first scan the task table and commit the best task.
// The priority scan examines one task per cycle; the next item is taken only after emit.
// A new item is taken while the previous result still waits on the output register.
// Reset (rst_n low at a clock edge, synchronous) leaves only the idle task, all slots empty.
`default_nettype none

module priority_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int MAX_TASKS      = 8,
  parameter int NUM_CONDITIONS = 8,
  parameter int PRIORITY_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] opcode, [9:2] task_priority, [12:10] condition_id, [15:13] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] current_task, [6:3] task_total, [8:7] fault, [24:9] error_total, [31:25] zero
  output logic [31:0]      out_tdata
);

  `include "assert_macros.svh"

  // Task index and task count widths. The count must be able to hold MAX_TASKS itself.
  localparam int TIDX_W = $clog2(MAX_TASKS);
  localparam int TCNT_W = $clog2(MAX_TASKS + 1);
  // The condition field is three bits wide, so at most eight slots can ever be reached.
  localparam int SLOT_COUNT = (NUM_CONDITIONS < 8) ? NUM_CONDITIONS : 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Sequencer state.
  upc_t   upc_r, upc_nxt;
  ucode_t uw;
  logic   step_go;

  // Latched input item.
  logic [1:0] item_op_r;
  logic [7:0] item_prio_r;
  logic [2:0] item_cond_r;

  // Task table and scheduler state.
  logic [PRIORITY_BITS-1:0] prio_r [MAX_TASKS];
  logic [MAX_TASKS-1:0]     runnable_r;
  logic [TCNT_W-1:0]        task_number_r;
  logic [TIDX_W-1:0]        running_r;
  logic [SLOT_COUNT-1:0]    slot_valid_r;
  logic [TIDX_W-1:0]        slot_task_r [SLOT_COUNT];
  logic [15:0]              err_r;
  logic [1:0]               fault_r;

  // Scan datapath.
  logic [TCNT_W-1:0]        walk_r;
  logic [TIDX_W-1:0]        best_r;
  logic [PRIORITY_BITS-1:0] best_prio_r;

  // Output register.
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  // Derived datapath values.
  logic [PRIORITY_BITS+7:0] prio_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [SLOT_W+2:0]        cond_ext;
  logic [SLOT_W-1:0]        slot_idx;
  logic                     cond_ok;
  logic [TIDX_W-1:0]        add_idx;
  logic [TIDX_W-1:0]        walk_idx;
  logic                     scan_more;
  logic                     table_full;
  logic [TIDX_W+2:0]        cur_ext;
  logic [TCNT_W+3:0]        tot_ext;

  assign uw = ucode_rom(upc_r);

  // A step executes once its handshake condition is met; otherwise it holds.
  always_comb begin
    case (uw.hold)
      HOLD_IN:  step_go = in_tvalid;
      HOLD_OUT: step_go = !out_tvalid_r || out_tready;
      default:  step_go = 1'b1;
    endcase
  end

  assign in_tready = (uw.hold == HOLD_IN);

  // The stored priority keeps the low PRIORITY_BITS bits of the field.
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, item_prio_r};
  assign new_prio = prio_ext[PRIORITY_BITS-1:0];

  assign cond_ext   = {{SLOT_W{1'b0}}, item_cond_r};
  assign slot_idx   = cond_ext[SLOT_W-1:0];
  assign cond_ok    = (32'(item_cond_r) < SLOT_COUNT);
  assign add_idx    = task_number_r[TIDX_W-1:0];
  assign walk_idx   = walk_r[TIDX_W-1:0];
  assign scan_more  = (walk_r < task_number_r);
  assign table_full = (task_number_r == TCNT_W'(MAX_TASKS));

  assign cur_ext = {3'b000, running_r};
  assign tot_ext = {4'b0000, task_number_r};

  // Step counter: next address from the control word.
  always_comb begin
    upc_nxt = upc_r;
    if (step_go) begin
      case (uw.jump)
        J_DISPATCH: begin
          case (opcode_t'(in_tdata[1:0]))
            OP_ADD:    upc_nxt = U_ADD;
            OP_WAIT:   upc_nxt = U_WAIT;
            OP_SIGNAL: upc_nxt = U_SIGNAL;
            default:   upc_nxt = U_SCAN_INIT;
          endcase
        end
        J_IF_SLOT: upc_nxt = cond_ok ? uw.target : U_EMIT;
        J_LOOP:    upc_nxt = scan_more ? upc_r : uw.target;
        default:   upc_nxt = uw.target;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Control state: task table flags, counts, running task, slots, error counter, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runnable_r    <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
      task_number_r <= TCNT_W'(1);
      running_r     <= '0;
      slot_valid_r  <= '0;
      err_r         <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps the register full.
      if (out_tvalid_r && out_tready && !(step_go && (uw.act == ACT_EMIT))) begin
        out_tvalid_r <= 1'b0;
      end
      if (step_go) begin
        case (uw.act)
          ACT_ADD: begin
            if (!table_full) begin
              runnable_r[add_idx] <= 1'b1;
              task_number_r       <= task_number_r + TCNT_W'(1);
            end
          end
          ACT_WAIT: begin
            if (cond_ok) begin
              if (slot_valid_r[slot_idx] && (err_r != 16'hFFFF)) begin
                err_r <= err_r + 16'd1;
              end
              slot_valid_r[slot_idx] <= 1'b1;
              runnable_r[running_r]  <= 1'b0;
            end
          end
          ACT_SIGNAL: begin
            if (cond_ok && slot_valid_r[slot_idx]) begin
              runnable_r[slot_task_r[slot_idx]] <= 1'b1;
              slot_valid_r[slot_idx]            <= 1'b0;
            end
          end
          ACT_COMMIT: running_r <= best_r;
          ACT_EMIT:   out_tvalid_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: item, priorities, slot owners, scan datapath, fault and result.
  always_ff @(posedge clk) begin
    if (step_go) begin
      case (uw.act)
        ACT_LATCH: begin
          item_op_r   <= in_tdata[1:0];
          item_prio_r <= in_tdata[9:2];
          item_cond_r <= in_tdata[12:10];
          fault_r     <= FAULT_NONE;
        end
        ACT_ADD: begin
          if (table_full) begin
            fault_r <= FAULT_FULL;
          end else begin
            prio_r[add_idx] <= new_prio;
          end
        end
        ACT_WAIT: begin
          if (cond_ok) begin
            if (slot_valid_r[slot_idx]) begin
              fault_r <= FAULT_OCCUPIED;
            end
            slot_task_r[slot_idx] <= running_r;
          end
        end
        ACT_SCAN_INIT: begin
          // The idle task always has priority zero.
          walk_r      <= TCNT_W'(1);
          best_r      <= '0;
          best_prio_r <= '0;
        end
        ACT_SCAN_STEP: begin
          if (scan_more) begin
            if (runnable_r[walk_idx] && (prio_r[walk_idx] > best_prio_r)) begin
              best_r      <= walk_idx;
              best_prio_r <= prio_r[walk_idx];
            end
            walk_r <= walk_r + TCNT_W'(1);
          end
        end
        ACT_EMIT: begin
          out_tdata_r <= {7'b0, err_r, fault_r, tot_ext[3:0], cur_ext[2:0]};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The table always holds the idle task and never more than MAX_TASKS entries.
  `ASSERT_ALWAYS(a_task_count,
    (task_number_r != '0) && (32'(task_number_r) <= MAX_TASKS),
    "task count out of range")

  // Between items the running task is runnable, unless it is the idle task.
  `ASSERT_IMPLIES(a_running_runnable, upc_r == U_FETCH,
    (running_r == '0) || runnable_r[running_r], "running task is blocked")

  // The error counter only ever counts up.
  `ASSERT_IMPLIES(a_err_monotonic, $past(rst_n), err_r >= $past(err_r),
    "error count went down")

  // A result appears only after the emit step.
  `ASSERT_IMPLIES(a_emit_source, $rose(out_tvalid_r), $past(upc_r == U_EMIT),
    "result raised outside the emit step")

  // Item opcode is only consulted for dispatch; keep the latched copy consistent.
  `ASSERT_IMPLIES(a_dispatch_match, (upc_r == U_ADD),
    opcode_t'(item_op_r) == OP_ADD, "add step entered for another opcode")

endmodule

`default_nettype wire
